// ===== rtl/sq8_pkg.sv =====
`default_nettype none
package sq8_pkg;

    localparam int DIM_W      = 10;
    localparam int CFG_W      = 11;
    localparam int MAX_DIM_DEF = 1024;
    localparam logic [CFG_W-1:0] DIM_COUNT_RESET = 11'd1024;

    localparam logic [2:0] REQ_TRAIN_BEGIN  = 3'd0;
    localparam logic [2:0] REQ_TRAIN_ELEM   = 3'd1;
    localparam logic [2:0] REQ_TRAIN_FINISH = 3'd2;
    localparam logic [2:0] REQ_QUANTIZE     = 3'd3;
    localparam logic [2:0] REQ_DEQUANTIZE   = 3'd4;
    localparam logic [2:0] REQ_DISTANCE     = 3'd5;

    localparam logic [1:0] KIND_CODE     = 2'd0;
    localparam logic [1:0] KIND_VALUE    = 2'd1;
    localparam logic [1:0] KIND_DISTANCE = 2'd2;
    localparam logic [1:0] KIND_TRAINED  = 2'd3;

    localparam logic [39:0] SCALE_ONE  = 40'h00_0100_0000;
    localparam logic [63:0] SAT63      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] RECIP_255  = 32'h8080_8081;
    localparam logic [31:0] MIN_INIT   = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX_INIT   = 32'h8000_0000;
    localparam logic [63:0] HH_LIMIT   = 64'h0000_0000_7FFF_FFFF;

endpackage
`default_nettype wire

// ===== rtl/scalar_quantizer_sq8.sv =====
`default_nettype none
// Per-dimension 8-bit min/max scalar quantizer with signed Q16.16 values. One request is
// taken at a time and o_in_stall stays high until its work is done; all multiplies go
// through one shared 40x32 multiplier and all divides through one restoring divide step
// under a sequencer, with the min, max and scale tables held in memories that have one
// read port and one write port. Train begin resets the min and max of each dimension in
// use, train finish reads, subtracts, multiplies and writes back each one in turn, and
// quantize runs up to eight divide steps. Results leave through an output register.
module scalar_quantizer_sq8 #(
    parameter int MAX_DIM = sq8_pkg::MAX_DIM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [sq8_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [2:0]                  i_req_type,
    input  wire logic [sq8_pkg::DIM_W-1:0]   i_dim_index,
    input  wire logic signed [31:0]          i_in_value,
    input  wire logic [7:0]                  i_code_a,
    input  wire logic [7:0]                  i_code_b,
    input  wire logic                        i_last_element,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_out_kind,
    output logic [7:0]                       o_out_code,
    output logic signed [31:0]               o_out_value,
    output logic [62:0]                      o_out_distance
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = sq8_pkg::CFG_W;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_BEGIN   = 5'd1;
    localparam logic [4:0] S_RD      = 5'd2;
    localparam logic [4:0] S_TE      = 5'd3;
    localparam logic [4:0] S_FIN_RD  = 5'd4;
    localparam logic [4:0] S_FIN_SUB = 5'd5;
    localparam logic [4:0] S_FIN_MUL = 5'd6;
    localparam logic [4:0] S_FIN_WR  = 5'd7;
    localparam logic [4:0] S_Q0      = 5'd8;
    localparam logic [4:0] S_QDIV    = 5'd9;
    localparam logic [4:0] S_DQ0     = 5'd10;
    localparam logic [4:0] S_DQ1     = 5'd11;
    localparam logic [4:0] S_DS0     = 5'd12;
    localparam logic [4:0] S_DS1     = 5'd13;
    localparam logic [4:0] S_DS2     = 5'd14;
    localparam logic [4:0] S_DS3     = 5'd15;
    localparam logic [4:0] S_DS4     = 5'd16;
    localparam logic [4:0] S_DS5     = 5'd17;
    localparam logic [4:0] S_EMIT    = 5'd18;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = (s > {1'b0, sq8_pkg::SAT63}) ? sq8_pkg::SAT63 : s[63:0];
    endfunction

    logic [31:0] mem_min   [MAX_DIM];
    logic [31:0] mem_max   [MAX_DIM];
    logic [39:0] mem_scale [MAX_DIM];

    logic [4:0]        r_state, n_state;
    logic [CW-1:0]     r_dim_count;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [2:0]        r_req, n_req;
    logic [sq8_pkg::DIM_W-1:0] r_dim, n_dim;
    logic signed [31:0] r_x, n_x;
    logic [7:0]        r_ca, n_ca, r_cb, n_cb;
    logic              r_last, n_last;
    logic [31:0]       r_rd_min, r_rd_max;
    logic [39:0]       r_rd_scale;
    logic signed [32:0] r_range, n_range;
    logic [63:0]       r_prod;
    logic [40:0]       r_rem, n_rem;
    logic [39:0]       r_sc, n_sc;
    logic [7:0]        r_q, n_q;
    logic [47:0]       r_t, n_t;
    logic [63:0]       r_acc, n_acc;
    logic [63:0]       r_sum, n_sum;
    logic [1:0]        r_res_kind, n_res_kind;
    logic [7:0]        r_res_code, n_res_code;
    logic [31:0]       r_res_value, n_res_value;
    logic [62:0]       r_res_dist, n_res_dist;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_kind, n_out_kind;
    logic [7:0]        r_out_code, n_out_code;
    logic [31:0]       r_out_value, n_out_value;
    logic [62:0]       r_out_dist, n_out_dist;

    logic [CW-1:0]     n_eff;
    logic              ok;
    logic              out_free;
    logic              accept;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic              we_mm, we_sc;
    logic [31:0]       wr_min, wr_max;
    logic [39:0]       wr_scale;
    logic [39:0]       mul_a;
    logic [31:0]       mul_b;
    logic [71:0]       prod_full;
    logic signed [32:0] diff;
    logic [40:0]       rem2;
    logic [7:0]        ad;
    logic signed [48:0] dq_sum;
    logic [24:0]       fin_q;
    logic [63:0]       sum_new;

    assign n_eff    = (32'(r_dim_count) > MAX_DIM) ? CW'(MAX_DIM) : r_dim_count;
    assign ok       = CW'(r_dim) < n_eff;
    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && (r_state == S_IDLE);

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out_kind;
    assign o_out_code     = r_out_code;
    assign o_out_value    = r_out_value;
    assign o_out_distance = r_out_dist;

    assign prod_full = {32'b0, mul_a} * {40'b0, mul_b};
    assign diff      = {r_x[31], r_x} - {r_rd_min[31], r_rd_min};
    assign rem2      = {r_rem[39:0], 1'b0};
    assign ad        = (r_ca >= r_cb) ? (r_ca - r_cb) : (r_cb - r_ca);
    assign dq_sum    = {{17{r_rd_min[31]}}, r_rd_min} + {9'b0, r_prod[47:8]};
    assign fin_q     = r_prod[63:39];
    assign sum_new   = sat_add(r_sum, r_acc);

    always_comb begin
        rd_addr = (r_state == S_FIN_RD) ? AW'(r_cnt) : AW'(r_dim);
        we_mm   = 1'b0;
        we_sc   = 1'b0;
        wr_addr = AW'(r_dim);
        wr_min  = sq8_pkg::MIN_INIT;
        wr_max  = sq8_pkg::MAX_INIT;
        wr_scale = sq8_pkg::SCALE_ONE;
        mul_a   = 40'(r_range[31:0]);
        mul_b   = sq8_pkg::RECIP_255;
        case (r_state)
            S_BEGIN: begin
                we_mm   = (r_cnt < n_eff);
                wr_addr = AW'(r_cnt);
            end
            S_TE: begin
                we_mm  = 1'b1;
                wr_min = ($signed(r_x) < $signed(r_rd_min)) ? r_x : r_rd_min;
                wr_max = ($signed(r_x) > $signed(r_rd_max)) ? r_x : r_rd_max;
            end
            S_FIN_WR: begin
                we_sc   = 1'b1;
                wr_addr = AW'(r_cnt);
                if (!r_range[32] && (r_range != '0)) begin
                    wr_scale = 40'(r_range[31:0]) + 40'(fin_q);
                end
            end
            S_DQ0: begin
                mul_a = r_rd_scale;
                mul_b = 32'(r_ca);
            end
            S_DS0: begin
                mul_a = r_rd_scale;
                mul_b = 32'(ad);
            end
            S_DS1: begin
                mul_a = 40'(r_prod[47:24]);
                mul_b = 32'(r_prod[47:24]);
            end
            S_DS2: begin
                mul_a = 40'(r_t[47:24]);
                mul_b = 32'(r_t[23:0]);
            end
            S_DS3: begin
                mul_a = 40'(r_t[23:0]);
                mul_b = 32'(r_t[23:0]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_mm) begin
            mem_min[wr_addr] <= wr_min;
            mem_max[wr_addr] <= wr_max;
        end
        if (we_sc) begin
            mem_scale[wr_addr] <= wr_scale;
        end
        r_rd_min   <= mem_min[rd_addr];
        r_rd_max   <= mem_max[rd_addr];
        r_rd_scale <= mem_scale[rd_addr];
        r_prod     <= prod_full[63:0];
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_req       = r_req;
        n_dim       = r_dim;
        n_x         = r_x;
        n_ca        = r_ca;
        n_cb        = r_cb;
        n_last      = r_last;
        n_range     = r_range;
        n_rem       = r_rem;
        n_sc        = r_sc;
        n_q         = r_q;
        n_t         = r_t;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_res_kind  = r_res_kind;
        n_res_code  = r_res_code;
        n_res_value = r_res_value;
        n_res_dist  = r_res_dist;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_code  = r_out_code;
        n_out_value = r_out_value;
        n_out_dist  = r_out_dist;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req  = i_req_type;
                    n_dim  = i_dim_index;
                    n_x    = i_in_value;
                    n_ca   = i_code_a;
                    n_cb   = i_code_b;
                    n_last = i_last_element;
                    n_cnt  = '0;
                    n_res_kind  = sq8_pkg::KIND_CODE;
                    n_res_code  = '0;
                    n_res_value = '0;
                    n_res_dist  = '0;
                    case (i_req_type)
                        sq8_pkg::REQ_TRAIN_BEGIN:  n_state = S_BEGIN;
                        sq8_pkg::REQ_TRAIN_FINISH: n_state = S_FIN_RD;
                        sq8_pkg::REQ_TRAIN_ELEM,
                        sq8_pkg::REQ_QUANTIZE,
                        sq8_pkg::REQ_DEQUANTIZE,
                        sq8_pkg::REQ_DISTANCE:     n_state = S_RD;
                        default:                   n_state = S_IDLE;
                    endcase
                end
            end
            S_BEGIN: begin
                if (r_cnt < n_eff) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                if (!ok) begin
                    if ((r_req == sq8_pkg::REQ_DISTANCE) && r_last) begin
                        n_res_kind = sq8_pkg::KIND_DISTANCE;
                        n_res_dist = r_sum[62:0];
                        n_sum      = '0;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    case (r_req)
                        sq8_pkg::REQ_TRAIN_ELEM: n_state = S_TE;
                        sq8_pkg::REQ_QUANTIZE:   n_state = S_Q0;
                        sq8_pkg::REQ_DEQUANTIZE: n_state = S_DQ0;
                        default:                 n_state = S_DS0;
                    endcase
                end
            end
            S_TE: begin
                n_state = S_IDLE;
            end
            S_FIN_RD: begin
                if (r_cnt < n_eff) begin
                    n_state = S_FIN_SUB;
                end else begin
                    n_res_kind = sq8_pkg::KIND_TRAINED;
                    n_state    = S_EMIT;
                end
            end
            S_FIN_SUB: begin
                n_range = {r_rd_max[31], r_rd_max} - {r_rd_min[31], r_rd_min};
                n_state = S_FIN_MUL;
            end
            S_FIN_MUL: begin
                n_state = S_FIN_WR;
            end
            S_FIN_WR: begin
                n_cnt   = r_cnt + 1'b1;
                n_state = S_FIN_RD;
            end
            S_Q0: begin
                n_res_kind = sq8_pkg::KIND_CODE;
                if (diff[32] || (diff == '0)) begin
                    n_res_code = '0;
                    n_state    = S_EMIT;
                end else if ((r_rd_scale == '0) || ({8'b0, diff} >= {1'b0, r_rd_scale})) begin
                    n_res_code = 8'hFF;
                    n_state    = S_EMIT;
                end else begin
                    n_rem   = {8'b0, diff};
                    n_sc    = r_rd_scale;
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = S_QDIV;
                end
            end
            S_QDIV: begin
                if (rem2 >= {1'b0, r_sc}) begin
                    n_rem = rem2 - {1'b0, r_sc};
                    n_q   = {r_q[6:0], 1'b1};
                end else begin
                    n_rem = rem2;
                    n_q   = {r_q[6:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(7)) begin
                    n_res_code = n_q;
                    n_state    = S_EMIT;
                end
            end
            S_DQ0: begin
                n_state = S_DQ1;
            end
            S_DQ1: begin
                n_res_kind = sq8_pkg::KIND_VALUE;
                if (dq_sum > 49'sh0_7FFF_FFFF) begin
                    n_res_value = 32'h7FFF_FFFF;
                end else if (dq_sum < -49'sh0_8000_0000) begin
                    n_res_value = 32'h8000_0000;
                end else begin
                    n_res_value = dq_sum[31:0];
                end
                n_state = S_EMIT;
            end
            S_DS0: begin
                n_state = S_DS1;
            end
            S_DS1: begin
                n_t     = r_prod[47:0];
                n_state = S_DS2;
            end
            S_DS2: begin
                n_acc   = (r_prod > sq8_pkg::HH_LIMIT) ? sq8_pkg::SAT63
                                                      : {r_prod[31:0], 32'b0};
                n_state = S_DS3;
            end
            S_DS3: begin
                n_acc   = sat_add(r_acc, {7'b0, r_prod[47:0], 9'b0});
                n_state = S_DS4;
            end
            S_DS4: begin
                n_acc   = sat_add(r_acc, {16'b0, r_prod[63:16]});
                n_state = S_DS5;
            end
            S_DS5: begin
                if (r_last) begin
                    n_res_kind = sq8_pkg::KIND_DISTANCE;
                    n_res_dist = sum_new[62:0];
                    n_sum      = '0;
                    n_state    = S_EMIT;
                end else begin
                    n_sum   = sum_new;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_code  = r_res_code;
                    n_out_value = r_res_value;
                    n_out_dist  = r_res_dist;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dim_count <= sq8_pkg::DIM_COUNT_RESET;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_dim_count <= i_cfg_data;
            end
        end
        r_req       <= n_req;
        r_dim       <= n_dim;
        r_x         <= n_x;
        r_ca        <= n_ca;
        r_cb        <= n_cb;
        r_last      <= n_last;
        r_range     <= n_range;
        r_rem       <= n_rem;
        r_sc        <= n_sc;
        r_q         <= n_q;
        r_t         <= n_t;
        r_acc       <= n_acc;
        r_res_kind  <= n_res_kind;
        r_res_code  <= n_res_code;
        r_res_value <= n_res_value;
        r_res_dist  <= n_res_dist;
        r_out_kind  <= n_out_kind;
        r_out_code  <= n_out_code;
        r_out_value <= n_out_value;
        r_out_dist  <= n_out_dist;
    end

    a_div_rem_below_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QDIV) |-> (r_rem < {1'b0, r_sc}))
        else $error("divide remainder reached the scale");

    a_scale_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we_sc |-> (wr_scale != '0))
        else $error("training finish wrote a zero scale");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DS5) && r_last) |=> (r_sum == '0))
        else $error("distance sum not cleared after the last element");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_BEGIN) || (r_state == S_FIN_SUB) || (r_state == S_FIN_WR))
        |-> (r_cnt <= n_eff))
        else $error("table sweep ran past the dimensions in use");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

    localparam int WATCH_LIMIT = 40000;
    localparam int IDLE_PAUSE  = 1200;
    localparam int HOLD_LEN    = 400;

    typedef struct {
        logic [1:0]         kind;
        logic [7:0]         code;
        logic signed [31:0] value;
        logic [62:0]        distance;
    } quant_result_t;

    class quant_scoreboard;
        int            dims_cfg;
        int            lo_tab[1024];
        int            hi_tab[1024];
        logic [39:0]   scale_tab[1024];
        logic [63:0]   dist_acc;
        quant_result_t pending[$];
        int            mismatches;

        function new();
            dims_cfg = sq8_pkg::DIM_COUNT_RESET;
            dist_acc = '0;
            mismatches = 0;
        endfunction

        function void note_request(logic [2:0] rq, logic [9:0] d, int x,
                                   logic [7:0] ca, logic [7:0] cb, logic last);
            int            n;
            bit            ok;
            longint        r;
            longint        diff;
            longint        q;
            longint        v;
            logic [127:0]  t;
            logic [127:0]  sq;
            logic [64:0]   sum;
            quant_result_t res;
            n = (dims_cfg > 1024) ? 1024 : dims_cfg;
            ok = d < n;
            res = '{kind: '0, code: '0, value: '0, distance: '0};
            case (rq)
                sq8_pkg::REQ_TRAIN_BEGIN: begin
                    for (int i = 0; i < n; i++) begin
                        lo_tab[i] = sq8_pkg::MIN_INIT;
                        hi_tab[i] = sq8_pkg::MAX_INIT;
                    end
                end
                sq8_pkg::REQ_TRAIN_ELEM: begin
                    if (ok) begin
                        if (x < lo_tab[d]) lo_tab[d] = x;
                        if (x > hi_tab[d]) hi_tab[d] = x;
                    end
                end
                sq8_pkg::REQ_TRAIN_FINISH: begin
                    for (int i = 0; i < n; i++) begin
                        r = longint'(hi_tab[i]) - longint'(lo_tab[i]);
                        scale_tab[i] = (r <= 0) ? sq8_pkg::SCALE_ONE : 40'((r * 256) / 255);
                    end
                    res.kind = sq8_pkg::KIND_TRAINED;
                    pending.push_back(res);
                end
                sq8_pkg::REQ_QUANTIZE: begin
                    if (ok) begin
                        diff = longint'(x) - longint'(lo_tab[d]);
                        if (diff <= 0) q = 0;
                        else if (scale_tab[d] == 0) q = 255;
                        else begin
                            q = (diff * 256) / longint'({24'd0, scale_tab[d]});
                            if (q > 255) q = 255;
                        end
                        res.kind = sq8_pkg::KIND_CODE;
                        res.code = 8'(q);
                        pending.push_back(res);
                    end
                end
                sq8_pkg::REQ_DEQUANTIZE: begin
                    if (ok) begin
                        v = longint'(lo_tab[d])
                            + longint'((64'(ca) * 64'(scale_tab[d])) >> 8);
                        if (v > 64'sd2147483647) v = 64'sd2147483647;
                        if (v < -64'sd2147483648) v = -64'sd2147483648;
                        res.kind = sq8_pkg::KIND_VALUE;
                        res.value = 32'(v);
                        pending.push_back(res);
                    end
                end
                sq8_pkg::REQ_DISTANCE: begin
                    if (ok) begin
                        t = 128'((ca >= cb) ? (ca - cb) : (cb - ca)) * 128'(scale_tab[d]);
                        sq = (t * t) >> 16;
                        if (sq > 128'(sq8_pkg::SAT63)) sq = 128'(sq8_pkg::SAT63);
                        sum = 65'(dist_acc) + 65'(sq[63:0]);
                        dist_acc = (sum > 65'(sq8_pkg::SAT63)) ? sq8_pkg::SAT63 : sum[63:0];
                    end
                    if (last) begin
                        res.kind = sq8_pkg::KIND_DISTANCE;
                        res.distance = dist_acc[62:0];
                        pending.push_back(res);
                        dist_acc = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(quant_result_t got);
            quant_result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: kind %0d code %0d value %0d dist %0d",
                             got.kind, got.code, got.value, got.distance);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.code !== want.code
                    || got.value !== want.value || got.distance !== want.distance) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected kind %0d code %0d value %0d dist %0d, %s %0d %0d %0d %0d",
                             want.kind, want.code, want.value, want.distance,
                             "got", got.kind, got.code, got.value, got.distance);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [10:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_req_type;
    logic [9:0]  i_dim_index;
    logic signed [31:0] i_in_value;
    logic [7:0]  i_code_a;
    logic [7:0]  i_code_b;
    logic        i_last_element;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_out_code;
    logic signed [31:0] o_out_value;
    logic [62:0] o_out_distance;

    quant_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    int quiet_cycles;
    int val_base;
    int val_span_log;

    scalar_quantizer_sq8 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(i_req_type), .i_dim_index(i_dim_index), .i_in_value(i_in_value),
        .i_code_a(i_code_a), .i_code_b(i_code_b), .i_last_element(i_last_element),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_kind(o_out_kind), .o_out_code(o_out_code),
        .o_out_value(o_out_value), .o_out_distance(o_out_distance)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        quant_result_t got;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(i_req_type, i_dim_index, i_in_value, i_code_a, i_code_b,
                                i_last_element);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                got.kind = o_out_kind;
                got.code = o_out_code;
                got.value = o_out_value;
                got.distance = o_out_distance;
                sb.check_result(got);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_req(logic [2:0] rq, logic [9:0] d, logic [31:0] x,
                            logic [7:0] ca, logic [7:0] cb, logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rq;
        i_dim_index <= d;
        i_in_value <= x;
        i_code_a <= ca;
        i_code_b <= cb;
        i_last_element <= last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_and_configure(int count);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= 11'(count);
        @(posedge i_clk);
        sb.dims_cfg = count;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return val_base + ($urandom & ((32'd1 << val_span_log) - 1));
    endfunction

    function automatic logic [9:0] pick_dim(int n);
        if (n == 0 || $urandom_range(0, 9) == 0) return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, n - 1));
    endfunction

    task automatic run_phase(int count, int n_train, int n_query, bit hold);
        int n;
        int pick;
        n = (count > 1024) ? 1024 : count;
        drain_and_configure(count);
        if (hold) hold_cycles = HOLD_LEN;
        val_base = $urandom;
        val_span_log = $urandom_range(0, 31);
        send_req(sq8_pkg::REQ_TRAIN_BEGIN, 10'($urandom), $urandom, 8'($urandom),
                 8'($urandom), 1'b0);
        for (int i = 0; i < n_train; i++)
            send_req(sq8_pkg::REQ_TRAIN_ELEM, pick_dim(n), pick_value(), 8'($urandom),
                     8'($urandom), 1'($urandom));
        send_req(sq8_pkg::REQ_TRAIN_FINISH, 10'($urandom), $urandom, 8'($urandom),
                 8'($urandom), 1'b0);
        for (int i = 0; i < n_query; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_req(sq8_pkg::REQ_QUANTIZE, pick_dim(n), pick_value(), 8'($urandom),
                         8'($urandom), 1'($urandom));
            else if (pick < 55)
                send_req(sq8_pkg::REQ_DEQUANTIZE, pick_dim(n), $urandom, 8'($urandom),
                         8'($urandom), 1'($urandom));
            else if (pick < 95)
                send_req(sq8_pkg::REQ_DISTANCE, pick_dim(n), $urandom, 8'($urandom),
                         8'($urandom), ($urandom_range(0, 3) == 0));
            else if (pick < 98)
                send_req(sq8_pkg::REQ_TRAIN_ELEM, pick_dim(n), pick_value(), 8'($urandom),
                         8'($urandom), 1'b0);
            else
                send_req(3'($urandom_range(6, 7)), 10'($urandom), $urandom, 8'($urandom),
                         8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int counts[12];
        sb = new();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_req_type = sq8_pkg::REQ_TRAIN_BEGIN;
        i_dim_index = '0;
        i_in_value = '0;
        i_code_a = '0;
        i_code_b = '0;
        i_last_element = 1'b0;
        i_out_stall = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme values, untrained and flat dimensions, index out of range.
        drain_and_configure(4);
        send_req(sq8_pkg::REQ_TRAIN_BEGIN, 10'd0, 32'd0, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_TRAIN_ELEM, 10'd0, 32'h8000_0000, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_TRAIN_ELEM, 10'd0, 32'h7FFF_FFFF, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_TRAIN_ELEM, 10'd1, 32'h0001_0000, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_TRAIN_ELEM, 10'd2, 32'hFFFF_0000, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_TRAIN_ELEM, 10'd2, 32'h0003_8000, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_TRAIN_ELEM, 10'd1023, 32'h1234_5678, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_TRAIN_FINISH, 10'd0, 32'd0, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_QUANTIZE, 10'd0, 32'h8000_0000, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_QUANTIZE, 10'd0, 32'h7FFF_FFFF, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_QUANTIZE, 10'd2, 32'h0001_2345, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_QUANTIZE, 10'd3, 32'h0000_0001, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_DEQUANTIZE, 10'd0, 32'd0, 8'd255, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_DEQUANTIZE, 10'd0, 32'd0, 8'd0, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_DEQUANTIZE, 10'd3, 32'd0, 8'd255, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_DEQUANTIZE, 10'd5, 32'd0, 8'd255, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_DISTANCE, 10'd0, 32'd0, 8'd255, 8'd0, 1'b0);
        send_req(sq8_pkg::REQ_DISTANCE, 10'd0, 32'd0, 8'd0, 8'd255, 1'b0);
        send_req(sq8_pkg::REQ_DISTANCE, 10'd900, 32'd0, 8'd10, 8'd3, 1'b1);
        send_req(sq8_pkg::REQ_DISTANCE, 10'd2, 32'd0, 8'd7, 8'd7, 1'b1);
        send_req(3'd6, 10'd1, 32'd0, 8'd0, 8'd0, 1'b1);
        send_req(3'd7, 10'd1, 32'd0, 8'd0, 8'd0, 1'b0);

        counts = '{1, 1024, 2047, 0, 7, 3, 16, 1, 5, 2, 33, 9};
        for (int p = 0; p < 12; p++) begin
            send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? 48 : 0;
            stall_pct = (p % 4 == 2) ? 48 : (p % 4 == 3) ? 27 : 0;
            if (p % 4 == 3) send_idle_pct = 27;
            run_phase(counts[p], (counts[p] > 64) ? 30 : 25, (counts[p] > 64) ? 40 : 55,
                      (p == 6));
        end

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== scalar_quantizer_sq8.f =====
rtl/sq8_pkg.sv
rtl/scalar_quantizer_sq8.sv
sim/testbench.sv
